### hdl/cst_pkg.sv
// ============================================================================
// cst_pkg
// Shared types, constants and tables of the cylinder side tessellator.
// ============================================================================
`default_nettype none

package cst_pkg;

    // Default angle resolution and number of rotation steps.
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Width of a phase numerator or denominator (twice the side count).
    localparam int PH_W = 17;

    // Width of the rotation datapath (Q2.30 plus guard bits).
    localparam int XW = 34;

    // CORDIC start value, 0.6072529350 in Q2.30.
    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

    // Smallest length, 0.01 in Q16.16, and unit length in Q1.14.
    localparam logic signed [31:0] MIN_LEN  = 32'sd655;
    localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;

    // Minimum number of sides.
    localparam logic [15:0] MIN_SIDES = 16'd3;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_RADIUS   = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_SIDES    = 3'd2,
        REG_CENTER_X = 3'd3,
        REG_CENTER_Y = 3'd4,
        REG_CENTER_Z = 3'd5
    } t_reg_idx;

    // Arctangent of 2^-k in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] v;
        case (k)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41721;
            15:      v = 32'd20860;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2607;
            19:      v = 32'd1303;
            20:      v = 32'd651;
            21:      v = 32'd325;
            22:      v = 32'd162;
            23:      v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hdl/cst_angle.sv
// ============================================================================
// cst_angle
// Pipelined phase divider and rotation-mode CORDIC: num/den turn to cos, sin.
// ============================================================================
`default_nettype none

module cst_angle #(
    parameter int ANGLE_BITS   = cst_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = cst_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [cst_pkg::PH_W-1:0]  i_num,
    input  wire logic [cst_pkg::PH_W-1:0]  i_den,
    output logic signed [31:0]             o_cos,
    output logic signed [31:0]             o_sin
);
    import cst_pkg::*;

    localparam int QW = ANGLE_BITS + 1;

    // Long division stages, one quotient bit each.
    logic [PH_W-1:0] r_rem [0:QW];
    logic [QW-1:0]   r_q   [0:QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_q[0]   <= '0;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_div
        logic [PH_W:0] w_t;
        logic [PH_W:0] w_d;
        logic          w_ge;
        assign w_t  = {r_rem[s], 1'b0};
        assign w_ge = (w_t >= {1'b0, i_den});
        assign w_d  = w_t - {1'b0, i_den};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_ge ? w_d[PH_W-1:0] : w_t[PH_W-1:0];
                r_q[s+1]   <= {r_q[s][QW-2:0], w_ge};
            end
        end
    end

    // Round the phase, then split it into a quadrant and a residue.
    logic [QW:0]       w_q1;
    logic [31:0]       w_p32;
    logic [31:0]       w_pq;
    logic [1:0]        w_quad;
    logic [31:0]       w_res;
    assign w_q1   = {1'b0, r_q[QW]} + {{QW{1'b0}}, 1'b1};
    assign w_p32  = {w_q1[ANGLE_BITS:1], {(32-ANGLE_BITS){1'b0}}};
    assign w_pq   = w_p32 + 32'h2000_0000;
    assign w_quad = w_pq[31:30];
    assign w_res  = w_p32 - {w_quad, 30'd0};

    logic signed [XW-1:0] r_x    [0:CORDIC_STEPS];
    logic signed [XW-1:0] r_y    [0:CORDIC_STEPS];
    logic signed [XW-1:0] r_z    [0:CORDIC_STEPS];
    logic [1:0]           r_quad [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= XW'(signed'(w_res));
            r_quad[0] <= w_quad;
        end
    end

    // Rotation steps; arithmetic shifts round toward minus infinity.
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        logic signed [XW-1:0] w_xs;
        logic signed [XW-1:0] w_ys;
        logic signed [XW-1:0] w_at;
        assign w_xs = r_x[k] >>> k;
        assign w_ys = r_y[k] >>> k;
        assign w_at = XW'(signed'({1'b0, atan_turn(k)}));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[k][XW-1]) begin
                    r_x[k+1] <= r_x[k] - w_ys;
                    r_y[k+1] <= r_y[k] + w_xs;
                    r_z[k+1] <= r_z[k] - w_at;
                end else begin
                    r_x[k+1] <= r_x[k] + w_ys;
                    r_y[k+1] <= r_y[k] - w_xs;
                    r_z[k+1] <= r_z[k] + w_at;
                end
                r_quad[k+1] <= r_quad[k];
            end
        end
    end

    // Put the quadrant back.
    logic signed [XW-1:0] w_xf;
    logic signed [XW-1:0] w_yf;
    logic signed [XW-1:0] w_nx;
    logic signed [XW-1:0] w_ny;
    assign w_xf = r_x[CORDIC_STEPS];
    assign w_yf = r_y[CORDIC_STEPS];
    assign w_nx = -w_xf;
    assign w_ny = -w_yf;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_quad[CORDIC_STEPS])
                2'd0: begin
                    o_cos <= w_xf[31:0];
                    o_sin <= w_yf[31:0];
                end
                2'd1: begin
                    o_cos <= w_ny[31:0];
                    o_sin <= w_xf[31:0];
                end
                2'd2: begin
                    o_cos <= w_nx[31:0];
                    o_sin <= w_ny[31:0];
                end
                default: begin
                    o_cos <= w_yf[31:0];
                    o_sin <= w_nx[31:0];
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/cylinder_side_tessellator_unit.sv
// ============================================================================
// cylinder_side_tessellator_unit
// Emits the twelve vertices (position and normal) of one side of a cylinder.
// ============================================================================
// A side index enters as one beat and leaves as twelve vertex beats, slot 0
// to 11, tlast on slot 11. The input port takes a new index in every cycle
// while the pipeline can move; the twelve-beat output port sets the sustained
// rate. From input beat to the first vertex an index passes one divider stage
// per phase bit plus one, one stage per CORDIC step, and stages for quadrant
// fix-up, the radius multiply, rounding and the center add with saturation.
// Three angle pipelines (near, far and mid angle) run side by side.
`default_nettype none

module cylinder_side_tessellator_unit #(
    parameter int ANGLE_BITS   = cst_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = cst_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Configuration write channel.
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    // Input stream.
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [15:0]   s_axis_tdata,  // [15:0] side_index
    // Output stream.
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [151:0]       m_axis_tdata,  // pos_x, pos_y, pos_z, norm_x,
                                              // norm_y, norm_z, vertex_slot, pad
    output logic               m_axis_tlast   // is_last
);
    import cst_pkg::*;

    localparam int LAT_A = ANGLE_BITS + CORDIC_STEPS + 4;
    localparam int LAT   = LAT_A + 3;

    // Configuration registers.
    logic signed [31:0] r_radius, r_height, r_cx, r_cy, r_cz;
    logic [15:0]        r_sides;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 32'sd65536;
            r_height <= 32'sd65536;
            r_sides  <= 16'd3;
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RADIUS:   r_radius <= i_cfg_data;
                REG_HEIGHT:   r_height <= i_cfg_data;
                REG_SIDES:    r_sides  <= i_cfg_data[15:0];
                REG_CENTER_X: r_cx     <= i_cfg_data;
                REG_CENTER_Y: r_cy     <= i_cfg_data;
                REG_CENTER_Z: r_cz     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped geometry.
    logic signed [31:0] w_rad;
    logic signed [31:0] w_hgt;
    logic [15:0]        w_sides;
    assign w_rad   = (r_radius <= 0) ? MIN_LEN : r_radius;
    assign w_hgt   = (r_height <= 0) ? MIN_LEN : r_height;
    assign w_sides = (r_sides < MIN_SIDES) ? MIN_SIDES : r_sides;

    // Input side: clamp the index and form the three phase fractions.
    logic [15:0]     w_idx;
    logic [PH_W-1:0] w_idx1;
    logic [PH_W-1:0] w_far;
    logic [PH_W-1:0] w_mid;
    logic [PH_W-1:0] w_den;
    logic [PH_W-1:0] w_den2;
    assign w_idx  = (s_axis_tdata > w_sides - 16'd1) ? w_sides - 16'd1 : s_axis_tdata;
    assign w_idx1 = {1'b0, w_idx} + 17'd1;
    assign w_far  = (w_idx1 == {1'b0, w_sides}) ? '0 : w_idx1;
    assign w_mid  = {w_idx, 1'b1};
    assign w_den  = {1'b0, w_sides};
    assign w_den2 = {w_sides, 1'b0};

    // Pipeline control: the whole pipe moves unless its tail is blocked.
    logic       r_vld [0:LAT-1];
    logic       r_busy;
    logic [3:0] r_slot;
    logic       w_last_beat, w_free, w_load, w_adv;

    assign w_last_beat = r_busy && m_axis_tready && (r_slot == 4'd11);
    assign w_free      = !r_busy || w_last_beat;
    assign w_load      = r_vld[LAT-1] && w_free;
    assign w_adv       = !r_vld[LAT-1] || w_load;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vld[i] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= s_axis_tvalid;
            for (int i = 1; i < LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // Angle pipelines.
    logic signed [31:0] w_cn, w_sn, w_cf, w_sf, w_cm, w_sm;

    cst_angle #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_near (
        .i_clk(i_clk), .i_en(w_adv), .i_num({1'b0, w_idx}), .i_den(w_den),
        .o_cos(w_cn), .o_sin(w_sn)
    );
    cst_angle #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_far (
        .i_clk(i_clk), .i_en(w_adv), .i_num(w_far), .i_den(w_den),
        .o_cos(w_cf), .o_sin(w_sf)
    );
    cst_angle #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_mid (
        .i_clk(i_clk), .i_en(w_adv), .i_num(w_mid), .i_den(w_den2),
        .o_cos(w_cm), .o_sin(w_sm)
    );

    // Stage M1: radius products and wall normals.
    logic signed [63:0] r_pnx, r_pnz, r_pfx, r_pfz;
    logic signed [15:0] r_wnx1, r_wnz1;
    logic signed [32:0] w_cmr, w_smr;
    logic signed [16:0] w_cmq, w_smq;
    assign w_cmr = 33'(w_cm) + 33'sd32768;
    assign w_smr = 33'(w_sm) + 33'sd32768;
    assign w_cmq = w_cmr[32:16];
    assign w_smq = w_smr[32:16];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pnx  <= 64'(w_rad) * 64'(w_cn);
            r_pnz  <= 64'(w_rad) * 64'(w_sn);
            r_pfx  <= 64'(w_rad) * 64'(w_cf);
            r_pfz  <= 64'(w_rad) * 64'(w_sf);
            r_wnx1 <= (w_cmq > 17'sd16384) ? UNIT_Q14 :
                      (w_cmq < -17'sd16384) ? -UNIT_Q14 : w_cmq[15:0];
            r_wnz1 <= (w_smq > 17'sd16384) ? UNIT_Q14 :
                      (w_smq < -17'sd16384) ? -UNIT_Q14 : w_smq[15:0];
        end
    end

    // Stage M2: round the offsets back to Q16.16.
    logic signed [33:0] r_onx, r_onz, r_ofx, r_ofz;
    logic signed [15:0] r_wnx2, r_wnz2;
    logic signed [63:0] w_rnx, w_rnz, w_rfx, w_rfz;
    assign w_rnx = r_pnx + 64'sd536870912;
    assign w_rnz = r_pnz + 64'sd536870912;
    assign w_rfx = r_pfx + 64'sd536870912;
    assign w_rfz = r_pfz + 64'sd536870912;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_onx  <= w_rnx[63:30];
            r_onz  <= w_rnz[63:30];
            r_ofx  <= w_rfx[63:30];
            r_ofz  <= w_rfz[63:30];
            r_wnx2 <= r_wnx1;
            r_wnz2 <= r_wnz1;
        end
    end

    // Stage M3: add the center and saturate.
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)       r = 32'sh7FFF_FFFF;
        else if (v < -35'sd2147483648) r = 32'sh8000_0000;
        else                           r = v[31:0];
        return r;
    endfunction

    logic signed [31:0] r_nx3, r_nz3, r_fx3, r_fz3, r_ty3;
    logic signed [15:0] r_wnx3, r_wnz3;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nx3  <= sat32(35'(r_cx) + 35'(r_onx));
            r_nz3  <= sat32(35'(r_cz) + 35'(r_onz));
            r_fx3  <= sat32(35'(r_cx) + 35'(r_ofx));
            r_fz3  <= sat32(35'(r_cz) + 35'(r_ofz));
            r_ty3  <= sat32(35'(r_cy) + 35'(w_hgt));
            r_wnx3 <= r_wnx2;
            r_wnz3 <= r_wnz2;
        end
    end

    // Output stage: holds one side and walks its twelve slots.
    logic signed [31:0] r_nx, r_nz, r_fx, r_fz, r_ty;
    logic signed [15:0] r_wnx, r_wnz;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_nx  <= r_nx3;
            r_nz  <= r_nz3;
            r_fx  <= r_fx3;
            r_fz  <= r_fz3;
            r_ty  <= r_ty3;
            r_wnx <= r_wnx3;
            r_wnz <= r_wnz3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_slot <= '0;
        end else if (w_last_beat) begin
            r_busy <= 1'b0;
        end else if (r_busy && m_axis_tready) begin
            r_slot <= r_slot + 4'd1;
        end
    end

    // Vertex selection per slot.
    logic signed [31:0] w_px, w_py, w_pz;
    logic signed [15:0] w_ox, w_oy, w_oz;

    always_comb begin
        w_px = r_cx;
        w_pz = r_cz;
        w_py = r_cy;
        w_ox = r_wnx;
        w_oy = '0;
        w_oz = r_wnz;
        case (r_slot)
            4'd1, 4'd5, 4'd7, 4'd10, 4'd11: begin
                w_px = r_nx;
                w_pz = r_nz;
            end
            4'd2, 4'd4, 4'd6, 4'd8, 4'd9: begin
                w_px = r_fx;
                w_pz = r_fz;
            end
            default: ;
        endcase
        case (r_slot)
            4'd3, 4'd4, 4'd5, 4'd7, 4'd8, 4'd11: w_py = r_ty;
            default: ;
        endcase
        case (r_slot)
            4'd0, 4'd1, 4'd2: begin
                w_ox = '0;
                w_oy = -UNIT_Q14;
                w_oz = '0;
            end
            4'd3, 4'd4, 4'd5: begin
                w_ox = '0;
                w_oy = UNIT_Q14;
                w_oz = '0;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tlast  = (r_slot == 4'd11);
    assign m_axis_tdata  = {4'd0, r_slot, w_oz, w_oy, w_ox, w_pz, w_py, w_px};

endmodule

`default_nettype wire

### hdl/cst_checker.sv
// ============================================================================
// cst_checker
// Port-level checks of the tessellator output stream.
// ============================================================================
`default_nettype none

module cst_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          m_axis_tvalid,
    input wire logic          m_axis_tready,
    input wire logic [151:0]  m_axis_tdata,
    input wire logic          m_axis_tlast
);

    // A stalled output beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("output beat changed while stalled");

    // The last marker sits exactly on slot eleven.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[147:144] == 4'd11)))
        else $error("tlast does not match slot");

    // Within a side the slots count up one by one without a gap.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tvalid && (m_axis_tdata[147:144] == $past(m_axis_tdata[147:144]) + 4'd1))
        else $error("slot sequence broken");

    // Bottom cap vertices carry the downward normal.
    a_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[147:144] == 4'd0 || m_axis_tdata[147:144] == 4'd1 ||
                          m_axis_tdata[147:144] == 4'd2) |->
        m_axis_tdata[111:96] == 16'h0000 && m_axis_tdata[127:112] == 16'hC000 &&
        m_axis_tdata[143:128] == 16'h0000)
        else $error("bottom cap normal wrong");

endmodule

bind cylinder_side_tessellator_unit cst_checker u_cst_checker (.*);

`default_nettype wire

### dv/cylinder_side_tessellator_unit_test.sv
// ============================================================================
// cylinder_side_tessellator_unit_test
// Self-checking bench: side indexes in, twelve checked vertex beats out.
// ============================================================================
// A directed table walks reset defaults, extremes, clamping and saturation. Random
// phases with fresh settings follow. Every vertex beat is compared with a
// fixed-point predictor of the rim angles, the CORDIC and the vertex layout.
`default_nettype none

module cylinder_side_tessellator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    // Register index outside the list; a write there must change nothing.
    localparam logic [2:0] REG_SPARE = 3'd6;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 20000;

    typedef enum logic {ROW_CFG, ROW_SIDE} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [31:0] data;
        bit          typed;
        logic [31:0] tx, ty, tz;
    } t_row;

    typedef struct packed {
        logic [31:0] px, py, pz;
        logic [15:0] nx, ny, nz;
        logic [3:0]  slot;
        logic        last;
    } t_vertex;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic         m_axis_tlast;

    cylinder_side_tessellator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // Shadow copy of the configuration.
    logic [31:0] sh_radius, sh_height, sh_cx, sh_cy, sh_cz;
    logic [15:0] sh_sides;

    t_vertex vertex_q[$];
    int      fails;
    int      stall_cnt;
    bit      quiet;

    longint atan_tab[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                             21354465, 10679838, 5340245, 2670163, 1335087,
                             667544, 333772, 166886, 83443, 41721, 20860};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Rounded phase of num/den turn, 16 bits.
    function automatic longint angle_phase(longint num, longint den);
        return (((num << 17) + den) / (2 * den)) & 64'hFFFF;
    endfunction

    // Rotation-mode CORDIC giving cos and sin in Q2.30.
    task automatic rotate(input longint phase, output longint c, output longint s);
        longint p, quad, z, x, y, t;
        p = (phase << 16) & 64'hFFFFFFFF;
        quad = ((p + 64'h20000000) >> 30) & 3;
        z = (p - (quad << 30)) & 64'hFFFFFFFF;
        if (z >= 64'sd2147483648) z -= 64'sd4294967296;
        x = 652032874;
        y = 0;
        for (int k = 0; k < 16; k++) begin
            if (z >= 0) begin
                t = x - (y >>> k);
                y = y + (x >>> k);
                z -= atan_tab[k];
            end else begin
                t = x + (y >>> k);
                y = y - (x >>> k);
                z += atan_tab[k];
            end
            x = t;
        end
        case (quad)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic logic [15:0] to_unit(longint f);
        longint v;
        v = (f + (64'sd1 << 15)) >>> 16;
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    // Predict the twelve vertices of one side and queue them.
    task automatic predict_side(input logic [15:0] side, input bit typed,
                                input logic [31:0] tx, ty, tz);
        longint n, idx, far_i, r, h, cx, cy, cz;
        longint cn, sn, cf, sf, cm, sm, nxp, nzp, fxp, fzp, tyy;
        logic [15:0] wnx, wnz, up, dn;
        t_vertex v[12];
        n = (sh_sides < 3) ? 3 : longint'(sh_sides);
        idx = side;
        r = longint'($signed(sh_radius));
        h = longint'($signed(sh_height));
        cx = longint'($signed(sh_cx));
        cy = longint'($signed(sh_cy));
        cz = longint'($signed(sh_cz));
        if (r <= 0) r = 655;
        if (h <= 0) h = 655;
        if (idx > n - 1) idx = n - 1;
        far_i = (idx + 1 == n) ? 0 : idx + 1;
        rotate(angle_phase(idx, n), cn, sn);
        rotate(angle_phase(far_i, n), cf, sf);
        rotate(angle_phase(2 * idx + 1, 2 * n), cm, sm);
        nxp = cx + ((r * cn + (64'sd1 << 29)) >>> 30);
        nzp = cz + ((r * sn + (64'sd1 << 29)) >>> 30);
        fxp = cx + ((r * cf + (64'sd1 << 29)) >>> 30);
        fzp = cz + ((r * sf + (64'sd1 << 29)) >>> 30);
        tyy = cy + h;
        wnx = to_unit(cm);
        wnz = to_unit(sm);
        up = UNIT_Q14;
        dn = -UNIT_Q14;
        v[0]  = '{sat32(cx),  sat32(cy),  sat32(cz),  16'd0, dn, 16'd0, 4'd0, 1'b0};
        v[1]  = '{sat32(nxp), sat32(cy),  sat32(nzp), 16'd0, dn, 16'd0, 4'd0, 1'b0};
        v[2]  = '{sat32(fxp), sat32(cy),  sat32(fzp), 16'd0, dn, 16'd0, 4'd0, 1'b0};
        v[3]  = '{sat32(cx),  sat32(tyy), sat32(cz),  16'd0, up, 16'd0, 4'd0, 1'b0};
        v[4]  = '{sat32(fxp), sat32(tyy), sat32(fzp), 16'd0, up, 16'd0, 4'd0, 1'b0};
        v[5]  = '{sat32(nxp), sat32(tyy), sat32(nzp), 16'd0, up, 16'd0, 4'd0, 1'b0};
        v[6]  = '{sat32(fxp), sat32(cy),  sat32(fzp), wnx, 16'd0, wnz, 4'd0, 1'b0};
        v[7]  = '{sat32(nxp), sat32(tyy), sat32(nzp), wnx, 16'd0, wnz, 4'd0, 1'b0};
        v[8]  = '{sat32(fxp), sat32(tyy), sat32(fzp), wnx, 16'd0, wnz, 4'd0, 1'b0};
        v[9]  = '{sat32(fxp), sat32(cy),  sat32(fzp), wnx, 16'd0, wnz, 4'd0, 1'b0};
        v[10] = '{sat32(nxp), sat32(cy),  sat32(nzp), wnx, 16'd0, wnz, 4'd0, 1'b0};
        v[11] = '{sat32(nxp), sat32(tyy), sat32(nzp), wnx, 16'd0, wnz, 4'd0, 1'b0};
        // A typed row fixes the bottom center vertex by hand.
        if (typed) begin
            v[0].px = tx;
            v[0].py = ty;
            v[0].pz = tz;
        end
        for (int k = 0; k < 12; k++) begin
            v[k].slot = k[3:0];
            v[k].last = (k == 11);
            vertex_q = {vertex_q, v[k]};
        end
    endtask

    // Random source gap before a beat; none during a quiet stretch.
    task automatic source_gap(output int cycles);
        cycles = 0;
        if (!quiet && $urandom_range(99) < 25) cycles = $urandom_range(1, 6);
    endtask

    task automatic send_side(input logic [15:0] side, input bit typed,
                             input logic [31:0] tx, ty, tz);
        int gap;
        i_cfg_valid <= 1'b0;
        source_gap(gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= side;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_side(side, typed, tx, ty, tz);
    endtask

    // Wait until every vertex has arrived and the pipeline has drained.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        i_cfg_valid   <= 1'b0;
        while (vertex_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Valid stays high so that writes can follow back to back; the next
    // drain or side beat drops it.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_RADIUS:   sh_radius = data;
            REG_HEIGHT:   sh_height = data;
            REG_SIDES:    sh_sides  = data[15:0];
            REG_CENTER_X: sh_cx     = data;
            REG_CENTER_Y: sh_cy     = data;
            REG_CENTER_Z: sh_cz     = data;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_len();
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return 32'h7FFFFFFF;
            2:       return 32'h80000000 | $urandom;
            3:       return $urandom;
            default: return $urandom_range(1, 32'h00200000);
        endcase
    endfunction

    function automatic logic [31:0] pick_center();
        case ($urandom_range(7))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return $urandom;
            default: return $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
        endcase
    endfunction

    function automatic logic [15:0] pick_sides();
        case ($urandom_range(11))
            0:       return 16'($urandom_range(0, 2));
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(3, 40));
        endcase
    endfunction

    // Output side: check each vertex beat, then choose the next ready.
    always @(posedge i_clk) begin
        t_vertex got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                    m_axis_tdata[111:96], m_axis_tdata[127:112],
                    m_axis_tdata[143:128], m_axis_tdata[147:144], m_axis_tlast};
            if (vertex_q.size() == 0) begin
                $display("%0t: unexpected vertex beat %h", $time, got);
                fails++;
            end else begin
                want = vertex_q.pop_front();
                if (got.px !== want.px)
                    $display("%0t: pos_x expected %h got %h", $time, want.px, got.px);
                if (got.py !== want.py)
                    $display("%0t: pos_y expected %h got %h", $time, want.py, got.py);
                if (got.pz !== want.pz)
                    $display("%0t: pos_z expected %h got %h", $time, want.pz, got.pz);
                if (got.nx !== want.nx)
                    $display("%0t: norm_x expected %h got %h", $time, want.nx, got.nx);
                if (got.ny !== want.ny)
                    $display("%0t: norm_y expected %h got %h", $time, want.ny, got.ny);
                if (got.nz !== want.nz)
                    $display("%0t: norm_z expected %h got %h", $time, want.nz, got.nz);
                if (got.slot !== want.slot)
                    $display("%0t: vertex_slot expected %0d got %0d", $time,
                             want.slot, got.slot);
                if (got.last !== want.last)
                    $display("%0t: tlast expected %b got %b", $time, want.last, got.last);
                if (got !== want) fails++;
            end
        end
        m_axis_tready <= quiet || ($urandom_range(99) >= 25);
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Directed table, then random phases.
    initial begin
        t_row rows[$];
        rows = '{
            '{ROW_SIDE, 3'd0, 32'd0, 1'b1, 32'd0, 32'd0, 32'd0},
            '{ROW_SIDE, 3'd0, 32'd1, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'd2, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'd5, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'hFFFF, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_SIDES, 32'd0, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_RADIUS, 32'd0, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_HEIGHT, 32'hFFFFFFFF, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'd1, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'h8000, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_RADIUS, 32'h7FFFFFFF, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_HEIGHT, 32'h7FFFFFFF, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_CENTER_X, 32'h7FFFFFFF, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_CENTER_Y, 32'h7FFFFFFF, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_CENTER_Z, 32'h80000000, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'd0, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000},
            '{ROW_SIDE, 3'd0, 32'd2, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_SPARE, 32'h12345678, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_SPARE + 3'd1, 32'hFFFFFFFF, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_SIDES, 32'h0000FFFF, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_RADIUS, 32'h80000000, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_CENTER_X, 32'h80000000, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_CENTER_Y, 32'h80000000, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_CENTER_Z, 32'h7FFFFFFF, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'd0, 1'b1, 32'h80000000, 32'h80000000, 32'h7FFFFFFF},
            '{ROW_SIDE, 3'd0, 32'd65533, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'd65534, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'hFFFF, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'h5555, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'hAAAA, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_SIDES, 32'd4, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_RADIUS, 32'd65536, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_CENTER_X, 32'd0, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_CENTER_Y, 32'd0, 1'b0, 0, 0, 0},
            '{ROW_CFG, REG_CENTER_Z, 32'd0, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'd0, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'd1, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'd2, 1'b0, 0, 0, 0},
            '{ROW_SIDE, 3'd0, 32'd3, 1'b0, 0, 0, 0}
        };
        fails = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_RADIUS;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        sh_radius = 32'd65536;
        sh_height = 32'd65536;
        sh_sides = MIN_SIDES;
        sh_cx = '0;
        sh_cy = '0;
        sh_cz = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Settings change only after the pipeline has drained.
        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                drain();
                write_reg(rows[r].idx, rows[r].data);
            end else begin
                send_side(rows[r].data[15:0], rows[r].typed,
                          rows[r].tx, rows[r].ty, rows[r].tz);
            end
        end

        // Random phases; the third one runs with no idling on either side.
        for (int ph = 0; ph < 7; ph++) begin
            logic [15:0] side;
            int          n;
            drain();
            write_reg(REG_RADIUS, pick_len());
            write_reg(REG_HEIGHT, pick_len());
            write_reg(REG_SIDES, pick_sides());
            write_reg(REG_CENTER_X, pick_center());
            write_reg(REG_CENTER_Y, pick_center());
            write_reg(REG_CENTER_Z, pick_center());
            quiet = (ph == 2);
            n = (sh_sides < 3) ? 3 : sh_sides;
            for (int it = 0; it < 60; it++) begin
                case ($urandom_range(9))
                    0:       side = 16'($urandom);
                    1:       side = 16'(n - 1 + $urandom_range(0, 3));
                    default: side = 16'($urandom_range(0, n - 1));
                endcase
                send_side(side, 1'b0, 0, 0, 0);
            end
        end
        quiet = 1'b0;

        drain();
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
